@@ rtl/core/idsm_pkg.sv @@
// Shared types, widths and constants of the input debounce and supply monitor.
// Used by idsm_pin_lane, idsm_supply and input_debounce_supply_monitor.
package idsm_pkg;

    // Number of debounced pins, 2 to 32.
    localparam int PIN_COUNT   = 9;

    localparam int SAMPLE_W    = 12;
    localparam int SCALE_SHIFT = 12;
    localparam int DEB_W       = 8;
    localparam int VOLT_W      = 10;
    localparam int AUX_W       = 9;
    localparam int QUAL_W      = 8;
    localparam int ACNT_W      = 8;

    localparam int SUPPLY_SCALE_W = 10;
    localparam int AUX_SCALE_W    = 9;
    localparam logic [SUPPLY_SCALE_W-1:0] SUPPLY_SCALE  = 10'd543;
    localparam logic [VOLT_W-1:0]         SUPPLY_OFFSET = 10'd21;
    localparam logic [AUX_SCALE_W-1:0]    AUX_SCALE     = 9'd363;

    localparam logic [VOLT_W-1:0] VOLT_MIN_RESET = 10'd1023;
    localparam logic [VOLT_W-1:0] VOLT_MAX_RESET = 10'd0;

    // Stream payload layout, first field in the lowest bits, padded to bytes.
    localparam int IN_BITS  = PIN_COUNT + 3 * SAMPLE_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = 2 * PIN_COUNT + 3 * VOLT_W + 2 * AUX_W + 4;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // Configuration port.
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] REG_EMERGENCY_DEBOUNCE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IGNITION_DEBOUNCE  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OTHER_DEBOUNCE     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOST_THRESHOLD     = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOST_RECOVER       = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD      = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_RECOVER        = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_QUALIFY_TICKS      = 8'd7;

    typedef struct packed {
        logic [DEB_W-1:0]  emergency_debounce;
        logic [DEB_W-1:0]  ignition_debounce;
        logic [DEB_W-1:0]  other_debounce;
        logic [VOLT_W-1:0] lost_threshold;
        logic [VOLT_W-1:0] lost_recover;
        logic [VOLT_W-1:0] low_threshold;
        logic [VOLT_W-1:0] low_recover;
        logic [QUAL_W-1:0] qualify_ticks;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        emergency_debounce: 8'd20,
        ignition_debounce:  8'd60,
        other_debounce:     8'd2,
        lost_threshold:     10'd50,
        lost_recover:       10'd80,
        low_threshold:      10'd150,
        low_recover:        10'd110,
        qualify_ticks:      8'd40
    };

    typedef struct packed {
        logic stable;
        logic changed;
    } lane_out_t;

    typedef struct packed {
        logic [VOLT_W-1:0] tenths;
        logic [VOLT_W-1:0] volt_min;
        logic [VOLT_W-1:0] volt_max;
        logic [AUX_W-1:0]  aux_one;
        logic [AUX_W-1:0]  aux_two;
        logic              lost_alarm;
        logic              under_alarm;
        logic              lost_event;
        logic              restored_event;
    } supply_res_t;

    // Debounce threshold of pin idx: pin zero and one have their own.
    function automatic logic [DEB_W-1:0] thr_of(cfg_t c, int idx);
        logic [DEB_W-1:0] thr;
        if (idx == 0)
        begin
            thr = c.emergency_debounce;
        end
        else if (idx == 1)
        begin
            thr = c.ignition_debounce;
        end
        else
        begin
            thr = c.other_debounce;
        end
        return thr;
    endfunction

endpackage

@@ rtl/core/idsm_pin_lane.sv @@
// One debounce lane: stable level and tick counter of a single pin.
// Depends on idsm_pkg.
module idsm_pin_lane (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic                       raw,
    input  logic [idsm_pkg::DEB_W-1:0] thr,
    output idsm_pkg::lane_out_t        res
);
    import idsm_pkg::*;

    logic             stable_reg;
    logic             stable_next;
    logic [DEB_W-1:0] count_reg;
    logic [DEB_W-1:0] count_next;
    logic [DEB_W-1:0] count_inc;
    logic             changed;

    assign count_inc = count_reg + 1'b1;

    always_comb
    begin
        stable_next = stable_reg;
        count_next  = count_reg;
        changed     = 1'b0;
        if (raw != stable_reg)
        begin
            if (thr == '0)
            begin
                // zero threshold: flip at once, leave the count alone
                stable_next = raw;
                changed     = 1'b1;
            end
            else if (count_inc >= thr)
            begin
                stable_next = raw;
                changed     = 1'b1;
                count_next  = '0;
            end
            else
            begin
                count_next = count_inc;
            end
        end
        else
        begin
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg <= 1'b1;
            count_reg  <= '0;
        end
        else if (step)
        begin
            stable_reg <= stable_next;
            count_reg  <= count_next;
        end
    end

    assign res.stable  = stable_next;
    assign res.changed = changed;

endmodule

@@ rtl/core/idsm_supply.sv @@
// Supply scaling, min/max tracking and power-lost / under-voltage alarms,
// plus scaling of the two auxiliary samples. Depends on idsm_pkg.
module idsm_supply (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  idsm_pkg::cfg_t                cfg,
    input  logic [idsm_pkg::SAMPLE_W-1:0] battery_sample,
    input  logic [idsm_pkg::SAMPLE_W-1:0] aux_one_sample,
    input  logic [idsm_pkg::SAMPLE_W-1:0] aux_two_sample,
    output idsm_pkg::supply_res_t         res
);
    import idsm_pkg::*;

    localparam int SPROD_W = SAMPLE_W + SUPPLY_SCALE_W;
    localparam int APROD_W = SAMPLE_W + AUX_SCALE_W;

    logic [SPROD_W-1:0] bat_prod;
    logic [APROD_W-1:0] aux_one_prod;
    logic [APROD_W-1:0] aux_two_prod;
    logic [VOLT_W-1:0]  tenths;

    logic [VOLT_W-1:0]  min_reg;
    logic [VOLT_W-1:0]  min_next;
    logic [VOLT_W-1:0]  max_reg;
    logic [VOLT_W-1:0]  max_next;
    logic [ACNT_W-1:0]  lost_cnt_reg;
    logic [ACNT_W-1:0]  lost_cnt_next;
    logic [ACNT_W-1:0]  low_cnt_reg;
    logic [ACNT_W-1:0]  low_cnt_next;
    logic               lost_flag_reg;
    logic               lost_flag_next;
    logic               low_flag_reg;
    logic               low_flag_next;
    logic               lost_ev;
    logic               restored_ev;

    assign bat_prod     = SPROD_W'(battery_sample) * SPROD_W'(SUPPLY_SCALE);
    assign aux_one_prod = APROD_W'(aux_one_sample) * APROD_W'(AUX_SCALE);
    assign aux_two_prod = APROD_W'(aux_two_sample) * APROD_W'(AUX_SCALE);
    assign tenths       = VOLT_W'(bat_prod >> SCALE_SHIFT) + SUPPLY_OFFSET;

    assign min_next = (tenths < min_reg) ? tenths : min_reg;
    assign max_next = (tenths > max_reg) ? tenths : max_reg;

    always_comb
    begin
        lost_cnt_next  = lost_cnt_reg;
        low_cnt_next   = low_cnt_reg;
        lost_flag_next = lost_flag_reg;
        low_flag_next  = low_flag_reg;
        lost_ev        = 1'b0;
        restored_ev    = 1'b0;

        // power lost first; raising it drops under-voltage
        if (tenths < cfg.lost_threshold)
        begin
            lost_cnt_next = lost_cnt_reg + 1'b1;
            if (lost_cnt_next == cfg.qualify_ticks && !lost_flag_reg)
            begin
                lost_flag_next = 1'b1;
                low_flag_next  = 1'b0;
                lost_ev        = 1'b1;
            end
        end
        else
        begin
            lost_cnt_next = '0;
            if (lost_flag_reg && tenths > cfg.lost_recover)
            begin
                lost_flag_next = 1'b0;
                restored_ev    = 1'b1;
            end
        end

        // under-voltage sees the updated power-lost state
        if (tenths < cfg.low_threshold)
        begin
            low_cnt_next = low_cnt_reg + 1'b1;
            if (low_cnt_next == cfg.qualify_ticks && !low_flag_next && !lost_flag_next)
            begin
                low_flag_next = 1'b1;
            end
        end
        else
        begin
            low_cnt_next = '0;
            if (low_flag_next && tenths > cfg.low_recover)
            begin
                low_flag_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg       <= VOLT_MIN_RESET;
            max_reg       <= VOLT_MAX_RESET;
            lost_cnt_reg  <= '0;
            low_cnt_reg   <= '0;
            lost_flag_reg <= 1'b0;
            low_flag_reg  <= 1'b0;
        end
        else if (step)
        begin
            min_reg       <= min_next;
            max_reg       <= max_next;
            lost_cnt_reg  <= lost_cnt_next;
            low_cnt_reg   <= low_cnt_next;
            lost_flag_reg <= lost_flag_next;
            low_flag_reg  <= low_flag_next;
        end
    end

    assign res.tenths         = tenths;
    assign res.volt_min       = min_next;
    assign res.volt_max       = max_next;
    assign res.aux_one        = AUX_W'(aux_one_prod >> SCALE_SHIFT);
    assign res.aux_two        = AUX_W'(aux_two_prod >> SCALE_SHIFT);
    assign res.lost_alarm     = lost_flag_next;
    assign res.under_alarm    = low_flag_next;
    assign res.lost_event     = lost_ev;
    assign res.restored_event = restored_ev;

endmodule

@@ rtl/core/input_debounce_supply_monitor.sv @@
// Top level of the input debounce and supply monitor: stream ports,
// configuration registers, pin lanes, supply unit and result register.
// Depends on idsm_pkg, idsm_pin_lane and idsm_supply.

// Each input item is one sample tick: PIN_COUNT raw pin levels plus the
// battery and two auxiliary ADC samples. One lane per pin debounces its
// level with its own tick counter (pin zero and one have private
// thresholds, the rest share one); the supply unit scales the battery
// sample to tenths of volts, tracks min/max and runs the power-lost and
// under-voltage alarms with hysteresis. All lanes and the supply unit
// update in the cycle the item is accepted, and the merged result lands
// in a single output register, so the block takes one item per clock
// unless stalled and presents its result from that register. s_tready
// stays high while the output register is empty or being drained in the
// same cycle; a stall on m_tready holds the result and back-pressures
// the input. Configuration writes are always accepted (cfg_ready is tied
// high) and should be issued only while no item is in flight; unknown
// indexes are dropped.
module input_debounce_supply_monitor (
    input  logic                            clk,
    input  logic                            rst_n,
    // input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [PIN_COUNT-1:0] pin_levels, then battery_sample, aux_one_sample,
    // aux_two_sample (12 bits each), zero padding
    input  logic [idsm_pkg::IN_W-1:0]       s_tdata,
    // result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // stable_levels, changed_pins (PIN_COUNT each), supply_tenths,
    // supply_min, supply_max (10 each), aux_one_scaled, aux_two_scaled
    // (9 each), power_lost_alarm, under_voltage_alarm, power_lost_event,
    // power_restored_event (1 each), zero padding
    output logic [idsm_pkg::OUT_W-1:0]      m_tdata,
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [idsm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [idsm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import idsm_pkg::*;

    localparam int BAT_LSB  = PIN_COUNT;
    localparam int AUX1_LSB = BAT_LSB + SAMPLE_W;
    localparam int AUX2_LSB = AUX1_LSB + SAMPLE_W;

    cfg_t                 cfg_reg;
    logic                 accept;
    logic [PIN_COUNT-1:0] pin_levels;
    logic [SAMPLE_W-1:0]  battery_sample;
    logic [SAMPLE_W-1:0]  aux_one_sample;
    logic [SAMPLE_W-1:0]  aux_two_sample;
    lane_out_t            lane_res [PIN_COUNT];
    logic [PIN_COUNT-1:0] stable_levels;
    logic [PIN_COUNT-1:0] changed_pins;
    supply_res_t          sup_res;
    logic [OUT_BITS-1:0]  result;
    logic                 out_valid_reg;
    logic [OUT_BITS-1:0]  out_data_reg;

    // Configuration registers: hold their value until rewritten.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_EMERGENCY_DEBOUNCE: cfg_reg.emergency_debounce <= cfg_data[DEB_W-1:0];
                REG_IGNITION_DEBOUNCE:  cfg_reg.ignition_debounce  <= cfg_data[DEB_W-1:0];
                REG_OTHER_DEBOUNCE:     cfg_reg.other_debounce     <= cfg_data[DEB_W-1:0];
                REG_LOST_THRESHOLD:     cfg_reg.lost_threshold     <= cfg_data[VOLT_W-1:0];
                REG_LOST_RECOVER:       cfg_reg.lost_recover       <= cfg_data[VOLT_W-1:0];
                REG_LOW_THRESHOLD:      cfg_reg.low_threshold      <= cfg_data[VOLT_W-1:0];
                REG_LOW_RECOVER:        cfg_reg.low_recover        <= cfg_data[VOLT_W-1:0];
                REG_QUALIFY_TICKS:      cfg_reg.qualify_ticks      <= cfg_data[QUAL_W-1:0];
                default:                cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Accept a new item whenever the result register is free or draining.
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Unpack the input item.
    assign pin_levels     = s_tdata[PIN_COUNT-1:0];
    assign battery_sample = s_tdata[BAT_LSB +: SAMPLE_W];
    assign aux_one_sample = s_tdata[AUX1_LSB +: SAMPLE_W];
    assign aux_two_sample = s_tdata[AUX2_LSB +: SAMPLE_W];

    // One debounce lane per pin, all advanced on the same accepted item.
    for (genvar i = 0; i < PIN_COUNT; i++)
    begin : g_lane
        idsm_pin_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .step  (accept),
            .raw   (pin_levels[i]),
            .thr   (thr_of(cfg_reg, i)),
            .res   (lane_res[i])
        );
        assign stable_levels[i] = lane_res[i].stable;
        assign changed_pins[i]  = lane_res[i].changed;
    end

    idsm_supply u_supply (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (accept),
        .cfg            (cfg_reg),
        .battery_sample (battery_sample),
        .aux_one_sample (aux_one_sample),
        .aux_two_sample (aux_two_sample),
        .res            (sup_res)
    );

    // Merge lane and supply findings into one result, first field lowest.
    assign result = {sup_res.restored_event, sup_res.lost_event,
                     sup_res.under_alarm, sup_res.lost_alarm,
                     sup_res.aux_two, sup_res.aux_one,
                     sup_res.volt_max, sup_res.volt_min, sup_res.tenths,
                     changed_pins, stable_levels};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload: load on accept, otherwise hold.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(out_data_reg);

    // Every accepted item shows up as a result in the next cycle.
    a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_tvalid)
        else $error("accepted item did not reach the result register");

    // Running minimum never exceeds running maximum once a tick is seen.
    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_data_reg[2*PIN_COUNT+VOLT_W +: VOLT_W]
                      <= out_data_reg[2*PIN_COUNT+2*VOLT_W +: VOLT_W]))
        else $error("supply_min above supply_max");

    // A power-lost event raises the alarm and drops under-voltage.
    a_lost_event: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && sup_res.lost_event) |-> (sup_res.lost_alarm && !sup_res.under_alarm))
        else $error("power lost event without consistent alarm flags");

    // A restore event clears the alarm and never coincides with a raise.
    a_restore_event: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && sup_res.restored_event) |-> (!sup_res.lost_alarm && !sup_res.lost_event))
        else $error("power restored event with alarm still set");

endmodule
